// ===== hdl/ps2_frame_receiver_fifo_core_defines.svh =====
// ----------------------------------------------------------------------------
// PS/2 receiver assertion macros
// Shared property macros for the receiver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PS2_FRAME_RECEIVER_FIFO_CORE_DEFINES_SVH
`define PS2_FRAME_RECEIVER_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PS2FR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PS2FR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ps2fr_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 receiver package
// Shared constants, payload structs and the command passed from front to back.
// ----------------------------------------------------------------------------
package ps2fr_pkg;

	localparam int RING_DEPTH_DEF = 64;
	localparam int FRAME_BITS     = 11;
	localparam int DATA_BITS      = 8;
	localparam int TIMEOUT_RESET  = 20;
	localparam int TIMEOUT_W      = 16;
	localparam int TIME_W         = 32;
	localparam int BIT_IDX_W      = 4;
	localparam int CMDQ_DEPTH     = 4;
	localparam int CMDQ_AW        = $clog2(CMDQ_DEPTH);

	// Input mode codes.
	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// What the back end has to do for one item.
	typedef enum logic [1:0] {
		CMD_EDGE,
		CMD_PUSH,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [DATA_BITS-1:0]   code;
	} cmd_t;

	typedef struct packed {
		logic                   mode;
		logic                   data_bit;
		logic [TIME_W-1:0]      time_ms;
	} in_item_t;

	typedef struct packed {
		logic [DATA_BITS-1:0]   code;
		logic                   code_valid;
		logic                   frame_done;
		logic                   dropped;
		logic                   has_data;
	} out_item_t;

endpackage

// ===== hdl/ps2fr_front.sv =====
// ----------------------------------------------------------------------------
// PS/2 receiver front end
// Holds the timeout register, times edges and assembles frames. Each beat
// becomes one command for the back end.
// ----------------------------------------------------------------------------
module ps2fr_front import ps2fr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	input  logic                 accept,
	input  in_item_t             item,
	output cmd_t                 cmd
);

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [BIT_IDX_W-1:0] bit_idx_q;
	logic [DATA_BITS-1:0] byte_q;
	logic [TIME_W-1:0]    last_q;

	logic [TIME_W-1:0]    gap;
	logic                 timed_out;
	logic [BIT_IDX_W-1:0] idx;
	logic [BIT_IDX_W-1:0] idx_m1;
	logic [DATA_BITS-1:0] byte_nx;
	logic                 last_bit;

	// Edge timing and bit placement.
	always_comb begin
		gap       = item.time_ms - last_q;
		timed_out = gap > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q};
		idx       = timed_out ? '0 : bit_idx_q;
		byte_nx   = timed_out ? '0 : byte_q;
		idx_m1    = idx - BIT_IDX_W'(1);
		if (idx != '0 && idx <= BIT_IDX_W'(DATA_BITS)) begin
			byte_nx[idx_m1[$clog2(DATA_BITS)-1:0]] = item.data_bit;
		end
		last_bit  = (idx == BIT_IDX_W'(FRAME_BITS - 1));
	end

	// Command for the back end.
	always_comb begin
		cmd.code = byte_nx;
		if (item.mode == MODE_READ) begin
			cmd.kind = CMD_READ;
		end else if (last_bit) begin
			cmd.kind = CMD_PUSH;
		end else begin
			cmd.kind = CMD_EDGE;
		end
	end

	// Timeout register and frame assembly state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_W'(TIMEOUT_RESET);
			bit_idx_q <= '0;
			byte_q    <= '0;
			last_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (accept && item.mode == MODE_EDGE) begin
				last_q <= item.time_ms;
				if (last_bit) begin
					bit_idx_q <= '0;
					byte_q    <= '0;
				end else begin
					bit_idx_q <= idx + BIT_IDX_W'(1);
					byte_q    <= byte_nx;
				end
			end
		end
	end

endmodule

// ===== hdl/ps2fr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// PS/2 receiver command queue
// Short queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module ps2fr_cmd_fifo import ps2fr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	input  logic  pop,
	output logic  full,
	output logic  nonempty,
	output cmd_t  head
);

	cmd_t                entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;

	assign full     = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (CMDQ_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (CMDQ_AW+1)'(1);
			end
		end
	end

endmodule

// ===== hdl/ps2fr_back.sv =====
// ----------------------------------------------------------------------------
// PS/2 receiver back end
// Runs commands against the scan code ring and holds the result register.
// ----------------------------------------------------------------------------
module ps2fr_back import ps2fr_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int AW = $clog2(RING_DEPTH);

	logic [DATA_BITS-1:0] ring_mem [RING_DEPTH];
	logic [DATA_BITS-1:0] rdata_q;
	logic [AW-1:0]        wr_idx_q;
	logic [AW-1:0]        rd_idx_q;
	logic                 out_valid_q;
	logic                 code_valid_q;
	logic                 frame_done_q;
	logic                 dropped_q;
	logic                 has_data_q;

	logic [AW-1:0]        wr_next;
	logic [AW-1:0]        rd_next;
	logic                 not_empty;
	logic                 not_full;
	logic                 do_write;
	logic                 do_read;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == AW'(RING_DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	// A command runs once the result register is free or being taken.
	assign cmd_pop   = cmd_valid && (!out_valid_q || !result_stall);
	assign wr_next   = ring_next(wr_idx_q);
	assign rd_next   = ring_next(rd_idx_q);
	assign not_empty = (rd_idx_q != wr_idx_q);
	assign not_full  = (wr_next != rd_idx_q);
	assign do_write  = cmd_pop && cmd.kind == CMD_PUSH && not_full;
	assign do_read   = cmd_pop && cmd.kind == CMD_READ && not_empty;

	// Ring storage with registered read data.
	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem[wr_idx_q] <= cmd.code;
		end
		if (do_read) begin
			rdata_q <= ring_mem[rd_idx_q];
		end
	end

	// Ring pointers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
			code_valid_q <= 1'b0;
			frame_done_q <= 1'b0;
			dropped_q    <= 1'b0;
			has_data_q   <= 1'b0;
		end else begin
			if (cmd_pop) begin
				out_valid_q <= 1'b1;
				case (cmd.kind)
					CMD_PUSH: begin
						code_valid_q <= 1'b0;
						frame_done_q <= 1'b1;
						dropped_q    <= !not_full;
						has_data_q   <= 1'b1;
						if (not_full) begin
							wr_idx_q <= wr_next;
						end
					end
					CMD_READ: begin
						code_valid_q <= not_empty;
						frame_done_q <= 1'b0;
						dropped_q    <= 1'b0;
						if (not_empty) begin
							rd_idx_q   <= rd_next;
							has_data_q <= (rd_next != wr_idx_q);
						end else begin
							has_data_q <= 1'b0;
						end
					end
					default: begin
						code_valid_q <= 1'b0;
						frame_done_q <= 1'b0;
						dropped_q    <= 1'b0;
						has_data_q   <= not_empty;
					end
				endcase
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result beat; the code reads as zero unless a pop delivered it.
	always_comb begin
		result.code       = code_valid_q ? rdata_q : '0;
		result.code_valid = code_valid_q;
		result.frame_done = frame_done_q;
		result.dropped    = dropped_q;
		result.has_data   = has_data_q;
	end

	assign result_valid = out_valid_q;

endmodule

// ===== hdl/ps2_frame_receiver_fifo_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 frame receiver with scan code queue
// Front end assembles frames, a command queue decouples it from the ring.
// ----------------------------------------------------------------------------
// Path: an accepted item enters the command queue, from which the back end
// runs it into the result register once that register is free or being taken.
// Throughput: one item per cycle while result_stall does not hold the queue, including pushes and pops.
// The single-port ring memory sees at most one write or one read per cycle.
// Reset: pointers and frame state clear at once; the timeout returns to 20 ms.
// Ring contents are not cleared; only written entries are ever read.
`include "ps2_frame_receiver_fifo_core_defines.svh"

module ps2_frame_receiver_fifo_core import ps2fr_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  in_item_t             item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_item_t            result
);

	logic item_accept;
	logic q_full;
	logic q_nonempty;
	logic cmd_pop;
	cmd_t front_cmd;
	cmd_t head_cmd;

	// Configuration beats are always taken.
	assign cfg_ready   = 1'b1;
	assign item_stall  = q_full;
	assign item_accept = item_valid && !q_full;

	ps2fr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.accept   (item_accept),
		.item     (item),
		.cmd      (front_cmd)
	);

	ps2fr_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (item_accept),
		.push_cmd (front_cmd),
		.pop      (cmd_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head_cmd)
	);

	ps2fr_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_nonempty),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A new result beat only appears after the back end ran a command.
	`PS2FR_ASSERT_NOW(a_result_from_cmd, $rose(result_valid), $past(cmd_pop), "result without command")
	// A drop is only reported on a completed frame.
	`PS2FR_ASSERT_NOW(a_drop_needs_frame, result_valid && result.dropped, result.frame_done, "drop without frame")
	// A popped code and a completed frame never share one beat.
	`PS2FR_ASSERT_NOW(a_pop_not_frame, result_valid && result.code_valid, !result.frame_done, "pop and frame in one beat")
	// A delivered frame always leaves data in the queue.
	`PS2FR_ASSERT_NEXT(a_push_has_data, cmd_pop && head_cmd.kind == CMD_PUSH, result.has_data, "queue empty after push")

endmodule
